### src/tekd_pkg.sv
// Package for the terminal escape-key decoder: request structs, byte constants
// and special key codes. Depends on nothing.
package tekd_pkg;

  // Input request: one received byte or one inter-byte timeout tick.
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_req_t;

  // Output request: a decoded key.
  typedef struct packed {
    logic       is_special;
    logic [7:0] key_code;
  } out_req_t;

  // Result of one parser step, handed from the parser to the output register.
  typedef struct packed {
    logic     hit;
    out_req_t key;
  } tekd_res_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] LBRACKET   = 8'h5B;
  localparam logic [7:0] SEMICOLON  = 8'h3B;
  localparam logic [7:0] TILDE      = 8'h7E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_FIVE  = 8'h35;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_D     = 8'h44;

  localparam logic [7:0] K_LEFT   = 8'd0;
  localparam logic [7:0] K_RIGHT  = 8'd1;
  localparam logic [7:0] K_UP     = 8'd2;
  localparam logic [7:0] K_DOWN   = 8'd3;
  localparam logic [7:0] K_CLEFT  = 8'd4;
  localparam logic [7:0] K_CRIGHT = 8'd5;
  localparam logic [7:0] K_DEL    = 8'd6;
  localparam logic [7:0] K_PGUP   = 8'd7;
  localparam logic [7:0] K_PGDN   = 8'd8;

endpackage

### src/terminal_escape_key_decoder.sv
// Top level of the terminal escape-key decoder: handshake and output register.
// Depends on tekd_pkg and tekd_parser.
//
//   Channel | Ports                         | Direction | Moves
//   --------+-------------------------------+-----------+-----------------------
//   input   | in_valid, in_stall, in_req    | in        | byte or timeout tick
//   output  | out_valid, out_stall, out_req | out       | decoded key, 0 or 1
//
// Each request is decoded in the cycle it is accepted, and its key (if any)
// appears in the output register on the next cycle, so one request is taken
// per cycle while in_stall is low; the parser's phase, held-byte and flag registers are its loops.
// Reset is synchronous and active low; it returns the parser to idle and
// empties the output register.
// The input is stalled only while the output register holds a key that the
// receiver is stalling; a draining output register is refilled in the same
// cycle.
module terminal_escape_key_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tekd_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output tekd_pkg::out_req_t out_req
);
  import tekd_pkg::*;

  logic      accept;
  tekd_res_t res;
  logic      out_valid_r;
  out_req_t  out_req_r;

  // Space exists when the register is empty or its key leaves this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  tekd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (accept),
    .req   (in_req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && res.hit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload register needs no reset; it loads only with a new key.
  always_ff @(posedge clk) begin
    if (accept && res.hit) begin
      out_req_r <= res.key;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

### src/tekd_parser.sv
// Escape sequence parser: phase state machine and one-step decode of a request.
// Depends on tekd_pkg.
module tekd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  tekd_pkg::in_req_t  req,
  output tekd_pkg::tekd_res_t res
);
  import tekd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ESC, PH_BRACKET, PH_OTHER, PH_ONE_A,
    PH_ONE_B, PH_ONE_C, PH_ONE_EXTRA, PH_TILDE
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       ctrl_ok_r, ctrl_ok_nxt;
  logic [7:0] b;
  logic       is_digit;

  assign b        = req.data_byte;
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    ctrl_ok_nxt  = ctrl_ok_r;
    res.hit      = 1'b0;
    res.key.is_special = 1'b0;
    res.key.key_code   = ESC_BYTE;
    if (req.op == OP_TICK) begin
      // A pending sequence collapses to a plain ESC; idle ticks vanish.
      if (phase_r != PH_IDLE) begin
        res.hit = 1'b1;
      end
      phase_nxt = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_ESC: begin
          phase_nxt = (b == LBRACKET) ? PH_BRACKET : PH_OTHER;
        end
        PH_OTHER, PH_ONE_EXTRA: begin
          res.hit   = 1'b1;
          phase_nxt = PH_IDLE;
        end
        PH_BRACKET: begin
          if (b == CHAR_ONE) begin
            ctrl_ok_nxt = 1'b1;
            phase_nxt   = PH_ONE_A;
          end else if (is_digit) begin
            held_nxt  = b;
            phase_nxt = PH_TILDE;
          end else begin
            res.hit   = 1'b1;
            phase_nxt = PH_IDLE;
            res.key.is_special = 1'b1;
            priority case (b)
              CHAR_A:  res.key.key_code = K_UP;
              CHAR_B:  res.key.key_code = K_DOWN;
              CHAR_C:  res.key.key_code = K_RIGHT;
              CHAR_D:  res.key.key_code = K_LEFT;
              default: begin
                res.key.is_special = 1'b0;
                res.key.key_code   = ESC_BYTE;
              end
            endcase
          end
        end
        PH_ONE_A: begin
          if (b != SEMICOLON) ctrl_ok_nxt = 1'b0;
          phase_nxt = PH_ONE_B;
        end
        PH_ONE_B: begin
          if (b != CHAR_FIVE) ctrl_ok_nxt = 1'b0;
          phase_nxt = PH_ONE_C;
        end
        PH_ONE_C: begin
          phase_nxt = PH_ONE_EXTRA;
          if (ctrl_ok_r && (b >= CHAR_A) && (b <= CHAR_D)) begin
            res.hit            = 1'b1;
            res.key.is_special = 1'b1;
            phase_nxt          = PH_IDLE;
            priority case (b)
              CHAR_D:  res.key.key_code = K_CLEFT;
              CHAR_C:  res.key.key_code = K_CRIGHT;
              CHAR_A:  res.key.key_code = K_UP;
              default: res.key.key_code = K_DOWN;
            endcase
          end
        end
        PH_TILDE: begin
          res.hit   = 1'b1;
          phase_nxt = PH_IDLE;
          if (b == TILDE) begin
            res.key.is_special = 1'b1;
            priority case (held_r)
              CHAR_THREE: res.key.key_code = K_DEL;
              CHAR_FIVE:  res.key.key_code = K_PGUP;
              CHAR_SIX:   res.key.key_code = K_PGDN;
              default: begin
                res.key.is_special = 1'b0;
                res.key.key_code   = ESC_BYTE;
              end
            endcase
          end
        end
        default: begin
          // Idle: ESC opens a sequence, anything else passes through.
          if (b == ESC_BYTE) begin
            phase_nxt = PH_ESC;
          end else begin
            res.hit          = 1'b1;
            res.key.key_code = b;
            phase_nxt        = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      held_r    <= '0;
      ctrl_ok_r <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      ctrl_ok_r <= ctrl_ok_nxt;
    end
  end

endmodule
